### sv/skoi_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key offset index package
// Shared widths, operation and status codes, and the cell control type.
// ----------------------------------------------------------------------------
package skoi_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned KeyChars   = 8;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned OffW   = 24;
  localparam int unsigned KindW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = $clog2(TableDepth + 1);

  localparam logic [KeyW-1:0] KeyAll  = {KeyW{1'b1}};
  localparam logic [KeyW-1:0] KeyMask = ~(KeyAll >> (8 * KeyChars));

  localparam logic [KindW-1:0] OP_LOOKUP = 2'd0;
  localparam logic [KindW-1:0] OP_INSERT = 2'd1;
  localparam logic [KindW-1:0] OP_DELETE = 2'd2;

  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatW-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [StatW-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic            ins;
    logic            del;
    logic [KeyW-1:0] key;
    logic [OffW-1:0] off;
  } skoi_ctrl_t;

endpackage

### sv/skoi_if.sv
// ----------------------------------------------------------------------------
// Sorted key offset index channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface skoi_req_if
  import skoi_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [KindW-1:0] kind;
  logic [KeyW-1:0]  search_key;
  logic [OffW-1:0]  record_offset;

  modport source (output valid, kind, search_key, record_offset, input ready);
  modport sink (input valid, kind, search_key, record_offset, output ready);
endinterface

interface skoi_rsp_if
  import skoi_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [OffW-1:0]  found_offset;

  modport source (output valid, status, found_offset, input ready);
  modport sink (input valid, status, found_offset, output ready);
endinterface

### sv/skoi_cell.sv
// ----------------------------------------------------------------------------
// Sorted key offset index cell
// Holds one key and offset, compares against the request key and shifts.
// ----------------------------------------------------------------------------
module skoi_cell
  import skoi_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmp_en_i,
  input  logic [KeyW-1:0] cmp_key_i,
  input  logic            valid_i,
  input  skoi_ctrl_t      ctrl_i,
  input  logic            prev_lt_i,
  input  logic [KeyW-1:0] prev_key_i,
  input  logic [OffW-1:0] prev_off_i,
  input  logic [KeyW-1:0] next_key_i,
  input  logic [OffW-1:0] next_off_i,
  output logic            lt_o,
  output logic            eq_o,
  output logic [KeyW-1:0] key_o,
  output logic [OffW-1:0] off_o
);

  logic            lt_q, lt_d;
  logic            eq_q, eq_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [OffW-1:0] off_q, off_d;

  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (cmp_en_i) begin
      lt_d = valid_i && (key_q < cmp_key_i);
      eq_d = valid_i && (key_q == cmp_key_i);
    end
  end

  always_comb begin
    key_d = key_q;
    off_d = off_q;
    if (ctrl_i.ins && !lt_q) begin
      if (prev_lt_i) begin
        key_d = ctrl_i.key;
        off_d = ctrl_i.off;
      end else begin
        key_d = prev_key_i;
        off_d = prev_off_i;
      end
    end else if (ctrl_i.del && !lt_q) begin
      key_d = next_key_i;
      off_d = next_off_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    off_q <= off_d;
  end

  assign lt_o  = lt_q;
  assign eq_o  = eq_q;
  assign key_o = key_q;
  assign off_o = off_q;

endmodule

### sv/sorted_key_offset_index.sv
// An accepted word is held in the execute register, then its response is registered.
// A new request is taken only when none is in flight and the output is free or ready.
// The cell row compares all keys in the accept cycle and shifts in the next.
// Reset clears the entry count and the handshake state; no clearing pass.
// ----------------------------------------------------------------------------
// Sorted key offset index
// Sorted table of key and offset pairs kept in a row of shifting cells.
// ----------------------------------------------------------------------------
module sorted_key_offset_index
  import skoi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  skoi_req_if.sink    in_i,
  skoi_rsp_if.source  out_o
);

  logic                exec_q, exec_d;
  logic [KindW-1:0]    kind_q;
  logic [KeyW-1:0]     key_q;
  logic [OffW-1:0]     off_q;
  logic [CountW-1:0]   count_q, count_d;
  logic                out_valid_q, out_valid_d;
  logic [StatW-1:0]    status_q, status_d;
  logic [OffW-1:0]     found_q, found_d;

  logic                accept;
  logic [KeyW-1:0]     cmp_key;
  logic [TableDepth-1:0] lt, eq;
  logic [KeyW-1:0]     cell_key [TableDepth];
  logic [OffW-1:0]     cell_off [TableDepth];
  logic                hit, full;
  logic [OffW-1:0]     hit_off;
  skoi_ctrl_t          ctrl;

  assign in_i.ready = !exec_q && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign cmp_key    = in_i.search_key & KeyMask;

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    logic            prev_lt;
    logic [KeyW-1:0] prev_key, next_key;
    logic [OffW-1:0] prev_off, next_off;
    logic            cell_valid;

    assign cell_valid = count_q > CountW'(i);

    if (i == 0) begin : g_first
      assign prev_lt  = 1'b1;
      assign prev_key = '0;
      assign prev_off = '0;
    end else begin : g_inner
      assign prev_lt  = lt[i-1];
      assign prev_key = cell_key[i-1];
      assign prev_off = cell_off[i-1];
    end

    if (i == TableDepth - 1) begin : g_last
      assign next_key = '0;
      assign next_off = '0;
    end else begin : g_body
      assign next_key = cell_key[i+1];
      assign next_off = cell_off[i+1];
    end

    skoi_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmp_en_i   (accept),
      .cmp_key_i  (cmp_key),
      .valid_i    (cell_valid),
      .ctrl_i     (ctrl),
      .prev_lt_i  (prev_lt),
      .prev_key_i (prev_key),
      .prev_off_i (prev_off),
      .next_key_i (next_key),
      .next_off_i (next_off),
      .lt_o       (lt[i]),
      .eq_o       (eq[i]),
      .key_o      (cell_key[i]),
      .off_o      (cell_off[i])
    );
  end

  assign hit  = |eq;
  assign full = count_q == CountW'(TableDepth);

  always_comb begin
    hit_off = '0;
    for (int i = 0; i < TableDepth; i++) begin
      hit_off = hit_off | (cell_off[i] & {OffW{eq[i]}});
    end
  end

  always_comb begin
    ctrl.ins = exec_q && (kind_q == OP_INSERT) && !hit && !full;
    ctrl.del = exec_q && (kind_q == OP_DELETE) && hit;
    ctrl.key = key_q;
    ctrl.off = off_q;
  end

  always_comb begin
    status_d    = status_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_o.ready;
    exec_d      = accept;
    count_d     = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CountW'(1);
    end else if (ctrl.del) begin
      count_d = count_q - CountW'(1);
    end
    if (exec_q) begin
      out_valid_d = 1'b1;
      found_d     = '0;
      unique case (kind_q)
        OP_LOOKUP: begin
          status_d = hit ? ST_OK : ST_NOT_FOUND;
          if (hit) begin
            found_d = hit_off;
          end
        end
        OP_INSERT: begin
          if (hit) begin
            status_d = ST_DUPLICATE;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_OK;
          end
        end
        OP_DELETE: begin
          status_d = hit ? ST_OK : ST_NOT_FOUND;
        end
        default: begin
          status_d = ST_NOT_FOUND;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      exec_q      <= exec_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_i.kind;
      key_q  <= cmp_key;
      off_q  <= in_i.record_offset;
    end
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.found_offset = found_q;

endmodule

### sv/skoi_checker.sv
// ----------------------------------------------------------------------------
// Sorted key offset index checker
// Port level checks on request timing and response contents.
// ----------------------------------------------------------------------------
module skoi_checker
  import skoi_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [StatW-1:0] out_status_i,
  input logic [OffW-1:0]  out_found_offset_i
);

  a_resp_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##2 out_valid_i)
    else $error("Response did not appear two cycles after a request word.");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("A second request word was taken while one is in flight.");

  a_offset_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_found_offset_i != '0) |-> out_status_i == ST_OK)
    else $error("A nonzero offset came with a status other than ok.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i))
    else $error("A stalled response word changed or was dropped.");

endmodule

bind sorted_key_offset_index skoi_checker u_skoi_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_status_i       (out_o.status),
  .out_found_offset_i (out_o.found_offset)
);
